@@ sv/c2dv_pkg.sv @@
// Shared types and constants for the multi-filter valid 2D convolution block.
package c2dv_pkg;

   localparam int KERNEL      = 3;
   localparam int MAX_FILTERS = 4;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;

   localparam int KK        = KERNEL * KERNEL;
   localparam int XW        = $clog2(MAX_WIDTH);
   localparam int WCW       = XW + 1;
   localparam int YW        = $clog2(MAX_HEIGHT);
   localparam int HCW       = YW + 1;
   localparam int FW        = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int PIX_W     = 8;
   localparam int WGT_W     = 16;
   localparam int LINE_BITS = ((KERNEL > 1) ? (KERNEL - 1) : 1) * PIX_W;
   localparam int PW        = PIX_W + 1 + WGT_W;
   localparam int SW        = PW + $clog2(KK);
   localparam int OUT_W     = 10;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [10:0] WIDTH_RESET   = 11'd1024;
   localparam logic [10:0] HEIGHT_RESET  = 11'd1024;
   localparam logic [4:0]  FILTERS_RESET = 5'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_FILTERS      = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_WEIGHT = 1'b0,
      MODE_PIXEL  = 1'b1
   } mode_type;

   typedef struct packed {
      logic               mode;
      logic [7:0]         pixel;
      logic signed [15:0] weight_value;
      logic [3:0]         weight_filter;
      logic [1:0]         weight_row;
      logic [1:0]         weight_col;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] conv_sum;
      logic [9:0]         out_x;
      logic [9:0]         out_y;
      logic [3:0]         filter_index;
      logic               last_filter;
   } rsp_item_type;

endpackage

@@ sv/c2dv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module c2dv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ sv/conv2d_valid_multi_filter.sv @@
// Top level: multi-filter valid 2D convolution with line buffers and a pixel window.
//
// Input channel (req_*): each item is a weight write (mode 0) or a raster-order
// pixel (mode 1). Result channel (rsp_*): one item per filter in use for every
// pixel whose window is complete, filter 0 first, last_filter set on the final one.
// Both channels: an item moves on a clock edge with valid high and stall low.
// csr_*: write-only register port; the user must write it only while the block
// is idle, which the block does not enforce. Flow: a pixel passes the input stage,
// window and filter sequencer, product stage, sum stage and result register; the
// single product/sum path takes its filters one per cycle unless a stall holds it.
// Throughput: one pixel per cycle while its window is incomplete and the sequencer
// is free, else the next pixel waits until every filter in use (1 to MAX_FILTERS)
// is issued; weight writes are held off while pixel work is still in flight.
// Reset: synchronous, clears the pipeline, counters and window; registers go to
// width 1024, height 1024, 4 filters; all weights read as zero. The line buffer
// RAM is not cleared and needs no clearing pass.
// Stall: a stalled result holds; the internal stages fill and then req_stall
// rises, so no item is lost or repeated.
module conv2d_valid_multi_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  c2dv_pkg::req_item_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output c2dv_pkg::rsp_item_type               rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [c2dv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [c2dv_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import c2dv_pkg::*;

   // configuration
   logic [10:0] width_cfg_ff;
   logic [10:0] height_cfg_ff;
   logic [4:0]  nf_cfg_ff;
   logic [WCW-1:0] width_lim;
   logic [HCW-1:0] height_lim;
   logic [FW-1:0]  nf_last;

   // position counters
   logic [XW-1:0]  col_cnt_ff;
   logic [YW-1:0]  row_cnt_ff;
   logic [WCW-1:0] x_plus;
   logic [HCW-1:0] y_plus;

   // input stage
   logic           accept;
   logic           s1_valid_ff;
   req_item_type   s1_item_ff;
   logic [XW-1:0]  s1_x_ff;
   logic [YW-1:0]  s1_y_ff;
   logic           s1_adv;
   logic           s1_free;
   logic           pixel_pending;

   // line buffer
   logic [LINE_BITS-1:0] line_rd;
   logic [LINE_BITS-1:0] line_wr;
   logic [PIX_W-1:0]     col_in [KERNEL];
   logic                 line_we;

   // window and filter sequencer
   logic [PIX_W-1:0] window_ff [KK];
   logic             e_busy_ff;
   logic [FW-1:0]    e_f_ff;
   logic [FW-1:0]    e_last_ff;
   logic [OUT_W-1:0] e_ox_ff;
   logic [OUT_W-1:0] e_oy_ff;
   logic             e_issue;
   logic             e_free;
   logic             e_start;

   // weight store
   logic                  wt_ok;
   int                    wt_tap;
   logic [MAX_FILTERS-1:0] wvalid_ff [KK];
   logic [KK-1:0]         wv_rd_ff;
   logic [WGT_W-1:0]      w_rd [KK];

   // product stage
   logic             t1_valid_ff;
   logic [FW-1:0]    t1_f_ff;
   logic             t1_last_ff;
   logic [OUT_W-1:0] t1_ox_ff;
   logic [OUT_W-1:0] t1_oy_ff;
   logic [PIX_W-1:0] t1_win_ff [KK];
   logic             t1_free;
   logic             t1_adv;
   logic signed [PW-1:0] prod_in [KK];

   // sum stage
   logic             t2_valid_ff;
   logic [FW-1:0]    t2_f_ff;
   logic             t2_last_ff;
   logic [OUT_W-1:0] t2_ox_ff;
   logic [OUT_W-1:0] t2_oy_ff;
   logic signed [PW-1:0] t2_prod_ff [KK];
   logic             t2_free;
   logic             rsp_load;
   logic signed [SW-1:0] sum_in;

   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= WIDTH_RESET;
         height_cfg_ff <= HEIGHT_RESET;
         nf_cfg_ff     <= FILTERS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_cfg_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_cfg_ff <= csr_wdata;
            CSR_FILTERS:      nf_cfg_ff     <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (int'(width_cfg_ff) < KERNEL) begin
         width_lim = WCW'(KERNEL);
      end else if (int'(width_cfg_ff) > MAX_WIDTH) begin
         width_lim = WCW'(MAX_WIDTH);
      end else begin
         width_lim = WCW'(width_cfg_ff);
      end
      if (int'(height_cfg_ff) < KERNEL) begin
         height_lim = HCW'(KERNEL);
      end else if (int'(height_cfg_ff) > MAX_HEIGHT) begin
         height_lim = HCW'(MAX_HEIGHT);
      end else begin
         height_lim = HCW'(height_cfg_ff);
      end
      if (nf_cfg_ff == 5'd0) begin
         nf_last = '0;
      end else if (int'(nf_cfg_ff) > MAX_FILTERS) begin
         nf_last = FW'(MAX_FILTERS - 1);
      end else begin
         nf_last = FW'(nf_cfg_ff - 5'd1);
      end
   end

   // ---------------------------------------------------------------- handshake
   assign pixel_pending = (s1_valid_ff && (s1_item_ff.mode == MODE_PIXEL)) || e_busy_ff
                          || t1_valid_ff || t2_valid_ff;
   assign s1_adv    = s1_valid_ff && ((s1_item_ff.mode == MODE_WEIGHT) || e_free);
   assign s1_free   = !s1_valid_ff || s1_adv;
   assign req_stall = !s1_free || ((req_data.mode == MODE_WEIGHT) && pixel_pending);
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------- counters
   assign x_plus = {1'b0, col_cnt_ff} + WCW'(1);
   assign y_plus = {1'b0, row_cnt_ff} + HCW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept && (req_data.mode == MODE_PIXEL)) begin
            if (x_plus >= width_lim) begin
               col_cnt_ff <= '0;
               row_cnt_ff <= (y_plus >= height_lim) ? '0 : YW'(y_plus);
            end else begin
               col_cnt_ff <= XW'(x_plus);
            end
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
         s1_x_ff    <= col_cnt_ff;
         s1_y_ff    <= row_cnt_ff;
      end
   end

   // ---------------------------------------------------------------- line buffer
   always_comb begin
      line_wr = '0;
      for (int r = 0; r < KERNEL - 1; r++) begin
         col_in[r] = line_rd[r*PIX_W +: PIX_W];
      end
      col_in[KERNEL-1] = s1_item_ff.pixel;
      for (int r = 0; r < KERNEL - 1; r++) begin
         line_wr[r*PIX_W +: PIX_W] = col_in[r+1];
      end
   end

   assign line_we = s1_adv && (s1_item_ff.mode == MODE_PIXEL) && (KERNEL > 1);

   c2dv_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (s1_x_ff),
      .wr_data (line_wr),
      .rd_en   (accept && (req_data.mode == MODE_PIXEL)),
      .rd_addr (col_cnt_ff),
      .rd_data (line_rd)
   );

   // ---------------------------------------------------------------- window, sequencer
   assign e_issue = e_busy_ff && t1_free;
   assign e_free  = !e_busy_ff || (e_issue && (e_f_ff == e_last_ff));
   assign e_start = s1_adv && (s1_item_ff.mode == MODE_PIXEL)
                    && (int'(s1_x_ff) >= KERNEL - 1) && (int'(s1_y_ff) >= KERNEL - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_busy_ff <= 1'b0;
         e_f_ff    <= '0;
         for (int t = 0; t < KK; t++) begin
            window_ff[t] <= '0;
         end
      end else begin
         if (s1_adv && (s1_item_ff.mode == MODE_PIXEL)) begin
            for (int r = 0; r < KERNEL; r++) begin
               for (int c = 0; c < KERNEL - 1; c++) begin
                  window_ff[r*KERNEL + c] <= window_ff[r*KERNEL + c + 1];
               end
               window_ff[r*KERNEL + KERNEL - 1] <= col_in[r];
            end
         end
         if (e_start) begin
            e_busy_ff <= 1'b1;
            e_f_ff    <= '0;
         end else if (e_issue) begin
            if (e_f_ff == e_last_ff) begin
               e_busy_ff <= 1'b0;
            end else begin
               e_f_ff <= e_f_ff + FW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e_start) begin
         e_last_ff <= nf_last;
         e_ox_ff   <= OUT_W'(s1_x_ff - XW'(KERNEL - 1));
         e_oy_ff   <= OUT_W'(s1_y_ff - YW'(KERNEL - 1));
      end
   end

   // ---------------------------------------------------------------- weight store
   assign wt_ok  = s1_valid_ff && (s1_item_ff.mode == MODE_WEIGHT)
                   && (int'(s1_item_ff.weight_filter) < MAX_FILTERS)
                   && (int'(s1_item_ff.weight_row) < KERNEL)
                   && (int'(s1_item_ff.weight_col) < KERNEL);
   assign wt_tap = int'(s1_item_ff.weight_row) * KERNEL + int'(s1_item_ff.weight_col);

   for (genvar g = 0; g < KK; g++) begin : g_tap
      c2dv_ram #(
         .WIDTH (WGT_W),
         .DEPTH (MAX_FILTERS)
      ) u_weight_ram (
         .clock   (clock),
         .wr_en   (wt_ok && (wt_tap == g)),
         .wr_addr (FW'(s1_item_ff.weight_filter)),
         .wr_data (s1_item_ff.weight_value),
         .rd_en   (e_issue),
         .rd_addr (e_f_ff),
         .rd_data (w_rd[g])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            wvalid_ff[g] <= '0;
         end else if (wt_ok && (wt_tap == g)) begin
            wvalid_ff[g][FW'(s1_item_ff.weight_filter)] <= 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (e_issue) begin
            wv_rd_ff[g] <= wvalid_ff[g][e_f_ff];
         end
      end

      assign prod_in[g] = $signed({1'b0, t1_win_ff[g]})
                          * (wv_rd_ff[g] ? $signed(w_rd[g]) : $signed(WGT_W'(0)));
   end

   // ---------------------------------------------------------------- product, sum, result
   assign rsp_load = t2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign t2_free  = !t2_valid_ff || rsp_load;
   assign t1_adv   = t1_valid_ff && t2_free;
   assign t1_free  = !t1_valid_ff || t1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (t1_free) begin
            t1_valid_ff <= e_issue;
         end
         if (t2_free) begin
            t2_valid_ff <= t1_adv;
         end
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= t2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e_issue) begin
         t1_f_ff    <= e_f_ff;
         t1_last_ff <= (e_f_ff == e_last_ff);
         t1_ox_ff   <= e_ox_ff;
         t1_oy_ff   <= e_oy_ff;
         for (int t = 0; t < KK; t++) begin
            t1_win_ff[t] <= window_ff[t];
         end
      end
      if (t1_adv) begin
         t2_f_ff    <= t1_f_ff;
         t2_last_ff <= t1_last_ff;
         t2_ox_ff   <= t1_ox_ff;
         t2_oy_ff   <= t1_oy_ff;
         for (int t = 0; t < KK; t++) begin
            t2_prod_ff[t] <= prod_in[t];
         end
      end
      if (rsp_load) begin
         rsp_ff.conv_sum     <= 32'(sum_in);
         rsp_ff.out_x        <= t2_ox_ff;
         rsp_ff.out_y        <= t2_oy_ff;
         rsp_ff.filter_index <= 4'(t2_f_ff);
         rsp_ff.last_filter  <= t2_last_ff;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int t = 0; t < KK; t++) begin
         sum_in = sum_in + SW'(t2_prod_ff[t]);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a weight item in the input stage never overlaps pixel work downstream
   a_weight_alone: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_item_ff.mode == MODE_WEIGHT))
      |-> !(e_busy_ff || t1_valid_ff || t2_valid_ff))
      else $error("weight item overlaps pixel work");

   // filter sequencer never runs past the last filter
   a_filter_bound: assert property (@(posedge clock) disable iff (reset)
      e_busy_ff |-> (e_f_ff <= e_last_ff))
      else $error("filter counter beyond last filter");

   // a new result only comes from a filled sum stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(t2_valid_ff))
      else $error("result valid without sum stage");

   // results of one pixel end with the last filter before the sequencer goes idle
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (e_issue && (e_f_ff == e_last_ff) && !e_start) |=> (!e_busy_ff && t1_last_ff))
      else $error("sequencer idle without last filter issued");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the multi-filter valid 2D convolution block.
module tb;
   import c2dv_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int SETTLE       = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 60;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_item_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_item_type           rsp_data;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   conv2d_valid_multi_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // convolution predictor state
   logic [10:0]        width_reg   = WIDTH_RESET;
   logic [10:0]        height_reg  = HEIGHT_RESET;
   logic [4:0]         filters_reg = FILTERS_RESET;
   logic [7:0]         line_mem [KERNEL-1][MAX_WIDTH] = '{default: '{default: '0}};
   logic [7:0]         win [KERNEL][KERNEL] = '{default: '{default: '0}};
   logic signed [15:0] coef [MAX_FILTERS*KK] = '{default: '0};
   int unsigned        col_pos = 0;
   int unsigned        row_pos = 0;
   rsp_item_type       sums_due [$];

   int  errors = 0;
   int  cycle_count = 0;
   int  pixels_sent = 0;
   int  weights_sent = 0;
   int  sums_checked = 0;
   int  frames_done = 0;
   int  input_stall_cycles = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;
   int  hold_req = 0;
   int  stall_left = 0;

   function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic predict(input req_item_type it);
      int unsigned  w, h, nf;
      logic [7:0]   column [KERNEL];
      longint       acc;
      rsp_item_type res;
      if (it.mode == MODE_WEIGHT) begin
         weights_sent++;
         if (it.weight_filter < MAX_FILTERS && it.weight_row < KERNEL && it.weight_col < KERNEL)
            coef[it.weight_filter*KK + it.weight_row*KERNEL + it.weight_col] = it.weight_value;
      end else begin
         pixels_sent++;
         w  = clamp_to(width_reg, KERNEL, MAX_WIDTH);
         h  = clamp_to(height_reg, KERNEL, MAX_HEIGHT);
         nf = clamp_to(filters_reg, 1, MAX_FILTERS);
         for (int r = 0; r < KERNEL - 1; r++)
            column[r] = line_mem[r][col_pos];
         column[KERNEL-1] = it.pixel;
         for (int r = 0; r < KERNEL - 1; r++)
            line_mem[r][col_pos] = column[r+1];
         for (int r = 0; r < KERNEL; r++) begin
            for (int c = 0; c < KERNEL - 1; c++)
               win[r][c] = win[r][c+1];
            win[r][KERNEL-1] = column[r];
         end
         if (col_pos >= KERNEL - 1 && row_pos >= KERNEL - 1) begin
            for (int f = 0; f < nf; f++) begin
               acc = 0;
               for (int r = 0; r < KERNEL; r++)
                  for (int c = 0; c < KERNEL; c++)
                     acc += longint'(win[r][c]) * longint'(coef[f*KK + r*KERNEL + c]);
               res.conv_sum     = acc[31:0];
               res.out_x        = 10'(col_pos - (KERNEL - 1));
               res.out_y        = 10'(row_pos - (KERNEL - 1));
               res.filter_index = 4'(f);
               res.last_filter  = (f == nf - 1);
               sums_due.push_back(res);
            end
         end
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
         end else begin
            col_pos++;
         end
      end
   endtask

   function automatic void check_field(string name, logic signed [31:0] want_v,
                                       logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t  %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset) begin
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (sums_due.size() == 0) begin
               errors++;
               $display("%0t  unexpected result: expected none, got sum %0d x %0d y %0d f %0d last %0b",
                        $time, rsp_data.conv_sum, rsp_data.out_x, rsp_data.out_y,
                        rsp_data.filter_index, rsp_data.last_filter);
            end else begin
               want = sums_due.pop_front();
               check_field("conv_sum", want.conv_sum, rsp_data.conv_sum);
               check_field("out_x", want.out_x, rsp_data.out_x);
               check_field("out_y", want.out_y, rsp_data.out_y);
               check_field("filter_index", want.filter_index, rsp_data.filter_index);
               check_field("last_filter", want.last_filter, rsp_data.last_filter);
               sums_checked++;
            end
         end
      end
   end

   // result receiver: random stall bursts plus long holds on request
   always @(negedge clock) begin
      if (hold_req > 0) begin
         stall_left = hold_req;
         hold_req   = 0;
      end
      if (stall_left == 0 && receiver_idles && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 10);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t  timeout with %0d results outstanding", $time, sums_due.size());
      $display("DONE: errors detected");
      $finish;
   end

   function automatic req_item_type rand_item();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(req_item_type)-1:0];
   endfunction

   function automatic req_item_type make_pixel(logic [7:0] p);
      req_item_type it;
      it       = rand_item();
      it.mode  = MODE_PIXEL;
      it.pixel = p;
      return it;
   endfunction

   function automatic req_item_type make_weight(int f, int r, int c, logic signed [15:0] v);
      req_item_type it;
      it               = rand_item();
      it.mode          = MODE_WEIGHT;
      it.weight_filter = 4'(f);
      it.weight_row    = 2'(r);
      it.weight_col    = 2'(c);
      it.weight_value  = v;
      return it;
   endfunction

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_coef();
      case ($urandom_range(0, 5))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly valid slots, sometimes any index (out-of-range ones are dropped)
   function automatic req_item_type rand_weight_item();
      if ($urandom_range(0, 5) == 0)
         return make_weight($urandom_range(0, 15), $urandom_range(0, 3),
                            $urandom_range(0, 3), rand_coef());
      return make_weight($urandom_range(0, MAX_FILTERS - 1), $urandom_range(0, KERNEL - 1),
                         $urandom_range(0, KERNEL - 1), rand_coef());
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      gap = (sender_idles && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict(it);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (sums_due.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:  width_reg   = val;
         CSR_IMAGE_HEIGHT: height_reg  = val;
         CSR_FILTERS:      filters_reg = val[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(int w, int h, int nf);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 11'(w));
      write_reg(CSR_IMAGE_HEIGHT, 11'(h));
      write_reg(CSR_FILTERS, 11'(nf));
   endtask

   task automatic load_all_weights();
      for (int f = 0; f < MAX_FILTERS; f++)
         for (int r = 0; r < KERNEL; r++)
            for (int c = 0; c < KERNEL; c++)
               send_item(make_weight(f, r, c, rand_coef()));
   endtask

   task automatic run_pixels(int count);
      for (int i = 0; i < count; i++)
         send_item(make_pixel(rand_pixel()));
   endtask

   // pixels until the counters wrap back to the frame origin
   task automatic run_frame(bit noisy);
      do begin
         if (noisy && $urandom_range(0, 11) == 0)
            send_item(rand_weight_item());
         if (noisy && $urandom_range(0, 59) == 0)
            wait_idle();
         send_item(make_pixel(rand_pixel()));
      end while (col_pos != 0 || row_pos != 0);
      frames_done++;
   endtask

   // default height and filter count; extreme weights and pixels, dropped writes
   task automatic test_directed();
      write_reg(CSR_IMAGE_WIDTH, 11'd3);
      for (int i = 0; i < KK; i++)
         send_item(make_weight(0, i / KERNEL, i % KERNEL, 16'sh8000));
      send_item(make_weight(1, 0, 0, 16'sh7FFF));
      send_item(make_weight(2, 1, 1, 16'sh0001));
      send_item(make_weight(3, 2, 2, -16'sd1));
      send_item(make_weight(15, 0, 0, 16'sh1234));
      send_item(make_weight(0, 3, 0, 16'sh1234));
      send_item(make_weight(0, 0, 3, 16'sh1234));
      for (int i = 0; i < KK; i++)
         send_item(make_pixel(i == KK / 2 ? 8'h00 : 8'hFF));
   endtask

   // rows deep into the default-height frame
   task automatic test_tall_frame();
      run_pixels(6 * KERNEL);
   endtask

   // register extremes; counters past a shrunken frame wrap when the current row ends
   task automatic test_register_limits();
      set_config(0, 0, 0);
      load_all_weights();
      run_frame(1'b0);
      run_frame(1'b0);
      set_config(2047, 3, 1);
      run_pixels(4 * KERNEL);
      set_config(3, 3, 31);
      run_frame(1'b0);
      set_config(3, 2047, 2);
      run_pixels(5 * KERNEL);
      set_config(3, 3, MAX_FILTERS);
      run_frame(1'b0);
      set_config(5, 4, 16);
      write_reg(CSR_SPARE, 11'($urandom));
      run_frame(1'b0);
   endtask

   task automatic test_backpressure();
      set_config(6, 5, MAX_FILTERS);
      sender_idles = 1'b0;
      hold_req     = HOLD_CYCLES;
      run_frame(1'b0);
      wait_idle();
      sender_idles = 1'b1;
   endtask

   task automatic test_random();
      int start;
      start = pixels_sent + weights_sent;
      while (pixels_sent + weights_sent - start < RANDOM_ITEMS) begin
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0 || pixels_sent + weights_sent == start)
            set_config($urandom_range(0, 4) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 9),
                       $urandom_range(0, 4) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 6),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 4));
         for (int i = $urandom_range(0, 6); i > 0; i--)
            send_item(rand_weight_item());
         run_frame(1'b1);
      end
   endtask

   task automatic test_quiet_tail();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      set_config(4, 4, MAX_FILTERS);
      run_frame(1'b0);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_tall_frame();
      test_register_limits();
      test_backpressure();
      test_random();
      test_quiet_tail();
      wait_idle();

      $display("covered %0d frames: %0d pixels, %0d weight writes, %0d sums checked",
               frames_done, pixels_sent, weights_sent, sums_checked);
      $display("register extremes, a %0d-cycle result hold, %0d cycles of input stall",
               HOLD_CYCLES, input_stall_cycles);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ conv2d_valid_multi_filter.f @@
sv/c2dv_pkg.sv
sv/c2dv_ram.sv
sv/conv2d_valid_multi_filter.sv
tb/sv/tb.sv
